// ----- src/box_blur_3x3_edge_aware_unit_assert.svh -----
// assertion macros for the blur unit
`ifndef BOX_BLUR_3X3_EDGE_AWARE_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_UNIT_ASSERT_SVH

`define BB3_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define BB3_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// ----- src/bb3_pkg.sv -----
package bb3_pkg;

   typedef struct packed {
      logic       mode;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last_of_image;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } sel_type;

   typedef struct packed {
      logic vld;
      logic flush;
      logic bank;
      logic e1;
      logic e2;
      logic up;
      logic down;
      logic left;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic [11:0] red;
      logic [11:0] green;
      logic [11:0] blue;
   } sum_type;

   typedef logic [1:0] cnt_type;

   localparam cnt_type CNT4 = 2'd0;
   localparam cnt_type CNT6 = 2'd1;
   localparam cnt_type CNT9 = 2'd2;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [10:0] WIDTH_RESET  = 11'd1024;
   localparam logic [15:0] HEIGHT_RESET = 16'd2;

   localparam logic [12:0] RECIP6 = 13'd5462;
   localparam logic [12:0] RECIP9 = 13'd3641;

   function automatic logic [11:0] byte_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic use_a,
                                           input logic use_c);
      logic [11:0] s;
      begin
         s = {4'd0, b};
         if (use_a) s = s + {4'd0, a};
         if (use_c) s = s + {4'd0, c};
         return s;
      end
   endfunction

   function automatic logic [7:0] div_round(input logic [11:0] s, input cnt_type cnt);
      logic [12:0] x;
      logic [25:0] p;
      logic [7:0]  q;
      begin
         x = 13'd0;
         p = 26'd0;
         q = 8'd0;
         case (cnt)
            CNT4: begin
               x = {1'b0, s} + 13'd2;
               q = x[9:2];
            end
            CNT6: begin
               x = {s, 1'b0} + 13'd6;
               p = {13'd0, x} * {13'd0, RECIP6};
               q = p[23:16];
            end
            CNT9: begin
               x = {s, 1'b0} + 13'd9;
               p = {13'd0, x} * {13'd0, RECIP9};
               q = p[23:16];
            end
            default: q = 8'd0;
         endcase
         return q;
      end
   endfunction

endpackage

// ----- src/bb3_cell.sv -----
module bb3_cell import bb3_pkg::*; (
   input  logic    clock,
   input  logic    shift,
   input  col_type col_in,
   output col_type col_out
);

   col_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ----- src/bb3_avg.sv -----
module bb3_avg import bb3_pkg::*; (
   input  logic    clock,
   input  col_type col_a,
   input  col_type col_b,
   input  col_type col_c,
   input  sel_type sel,
   output pix_type avg
);

   sum_type     sum_in;
   sum_type     sum_ff;
   cnt_type     cnt_in;
   cnt_type     cnt_ff;
   pix_type     avg_ff;
   logic        rows3;
   logic        cols3;
   logic [11:0] ra_r, rb_r, rc_r, ra_g, rb_g, rc_g, ra_b, rb_b, rc_b;

   always_comb begin
      ra_r = byte_sum(col_a.top.red,   col_a.mid.red,   col_a.bot.red,   sel.up, sel.down);
      rb_r = byte_sum(col_b.top.red,   col_b.mid.red,   col_b.bot.red,   sel.up, sel.down);
      rc_r = byte_sum(col_c.top.red,   col_c.mid.red,   col_c.bot.red,   sel.up, sel.down);
      ra_g = byte_sum(col_a.top.green, col_a.mid.green, col_a.bot.green, sel.up, sel.down);
      rb_g = byte_sum(col_b.top.green, col_b.mid.green, col_b.bot.green, sel.up, sel.down);
      rc_g = byte_sum(col_c.top.green, col_c.mid.green, col_c.bot.green, sel.up, sel.down);
      ra_b = byte_sum(col_a.top.blue,  col_a.mid.blue,  col_a.bot.blue,  sel.up, sel.down);
      rb_b = byte_sum(col_b.top.blue,  col_b.mid.blue,  col_b.bot.blue,  sel.up, sel.down);
      rc_b = byte_sum(col_c.top.blue,  col_c.mid.blue,  col_c.bot.blue,  sel.up, sel.down);
      sum_in.red   = rb_r + (sel.left ? ra_r : 12'd0) + (sel.right ? rc_r : 12'd0);
      sum_in.green = rb_g + (sel.left ? ra_g : 12'd0) + (sel.right ? rc_g : 12'd0);
      sum_in.blue  = rb_b + (sel.left ? ra_b : 12'd0) + (sel.right ? rc_b : 12'd0);
      rows3 = sel.up & sel.down;
      cols3 = sel.left & sel.right;
      if (rows3 && cols3) begin
         cnt_in = CNT9;
      end else if (rows3 || cols3) begin
         cnt_in = CNT6;
      end else begin
         cnt_in = CNT4;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      avg_ff.red   <= div_round(sum_ff.red,   cnt_ff);
      avg_ff.green <= div_round(sum_ff.green, cnt_ff);
      avg_ff.blue  <= div_round(sum_ff.blue,  cnt_ff);
   end

   assign avg = avg_ff;

endmodule

// ----- src/box_blur_3x3_edge_aware_unit.sv -----
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_data (req_type)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
// One request per cycle while req_stall is low.
// Row ends give two results; an eight-entry output queue absorbs them.
// req_stall rises when the queue plus four pipeline stages could overfill.
// Synchronous reset clears counters, queue and valid bits; line stores
// need no clearing.
module box_blur_3x3_edge_aware_unit import bb3_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int EW    = (CW > 11) ? CW : 11;
   localparam int DEPTH = 8;
   localparam int PW    = $clog2(DEPTH);

   typedef struct packed {
      rsp_type res0;
      rsp_type res1;
      logic    two;
   } entry_type;

   logic [10:0]   width_ff;
   logic [15:0]   height_ff;
   logic [EW-1:0] w_eff, wm1;
   logic [15:0]   h_eff;
   logic [AW-1:0] col_ff, col_in, flush_ff, flush_in, c_pos;
   logic [15:0]   row_ff, row_in;
   logic          accept, issue, item_ok;
   ctl_type       ctl_in, a_ctl_ff, b_ctl_ff, s1_ctl_ff, s2_ctl_ff;
   pix_type       a_pix_ff, pix;
   pix_type       mem0 [MAX_WIDTH];
   pix_type       mem1 [MAX_WIDTH];
   pix_type       rd0_ff, rd1_ff;
   col_type       new_col, win0, win1, win2;
   sel_type       sel1, sel2;
   pix_type       avg1, avg2;
   entry_type     fifo [DEPTH];
   entry_type     head, push_entry;
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff;
   logic          sub_ff, push, pop;
   logic [PW:0]   inflight;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data[10:0];
            REG_HEIGHT: height_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   always_comb begin
      if ({{(EW-11){1'b0}}, width_ff} < EW'(2)) begin
         w_eff = EW'(2);
      end else if ({{(EW-11){1'b0}}, width_ff} > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = {{(EW-11){1'b0}}, width_ff};
      end
      wm1   = w_eff - EW'(1);
      h_eff = (height_ff < 16'd2) ? 16'd2 : height_ff;
   end

   assign inflight = (PW+1)'(a_ctl_ff.vld) + (PW+1)'(b_ctl_ff.vld)
                   + (PW+1)'(s1_ctl_ff.vld) + (PW+1)'(s2_ctl_ff.vld);
   assign req_stall = (count_ff + inflight) >= (PW+1)'(DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pix.red   = req_data.in_red;
      pix.green = req_data.in_green;
      pix.blue  = req_data.in_blue;
      col_in    = col_ff;
      row_in    = row_ff;
      flush_in  = flush_ff;
      ctl_in    = '0;
      item_ok   = req_data.mode ? (row_ff >= h_eff) : (row_ff < h_eff);
      issue     = accept && item_ok;
      if (req_data.mode) begin
         c_pos = ({{(EW-AW){1'b0}}, flush_ff} > wm1) ? wm1[AW-1:0] : flush_ff;
      end else begin
         c_pos = ({{(EW-AW){1'b0}}, col_ff} > wm1) ? wm1[AW-1:0] : col_ff;
      end
      ctl_in.vld   = issue;
      ctl_in.flush = req_data.mode;
      ctl_in.bank  = row_ff[0];
      ctl_in.left  = {{(EW-AW){1'b0}}, c_pos} >= EW'(2);
      if (req_data.mode) begin
         ctl_in.e1   = c_pos != '0;
         ctl_in.e2   = {{(EW-AW){1'b0}}, c_pos} == wm1;
         ctl_in.up   = 1'b1;
         ctl_in.down = 1'b0;
         ctl_in.last = ctl_in.e2;
      end else begin
         ctl_in.e1   = (row_ff != 16'd0) && (c_pos != '0);
         ctl_in.e2   = (row_ff != 16'd0) && ({{(EW-AW){1'b0}}, c_pos} == wm1);
         ctl_in.up   = row_ff >= 16'd2;
         ctl_in.down = row_ff < h_eff;
         ctl_in.last = 1'b0;
      end
      if (issue) begin
         if (req_data.mode) begin
            if ({{(EW-AW){1'b0}}, c_pos} == wm1) begin
               row_in   = 16'd0;
               col_in   = '0;
               flush_in = '0;
            end else begin
               flush_in = c_pos + AW'(1);
            end
         end else begin
            if ({{(EW-AW){1'b0}}, c_pos} == wm1) begin
               col_in = '0;
               if ((row_ff + 16'd1) >= h_eff) begin
                  row_in   = h_eff;
                  flush_in = '0;
               end else begin
                  row_in = row_ff + 16'd1;
               end
            end else begin
               col_in = c_pos + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         flush_ff  <= '0;
         a_ctl_ff  <= '0;
         b_ctl_ff  <= '0;
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         flush_ff  <= flush_in;
         a_ctl_ff  <= ctl_in;
         b_ctl_ff  <= a_ctl_ff;
         s1_ctl_ff <= b_ctl_ff;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_pix_ff <= pix;
      rd0_ff   <= mem0[c_pos];
      rd1_ff   <= mem1[c_pos];
      if (issue && !req_data.mode && !row_ff[0]) begin
         mem0[c_pos] <= pix;
      end
      if (issue && !req_data.mode && row_ff[0]) begin
         mem1[c_pos] <= pix;
      end
   end

   always_comb begin
      new_col.top = a_ctl_ff.bank ? rd1_ff : rd0_ff;
      new_col.mid = a_ctl_ff.bank ? rd0_ff : rd1_ff;
      new_col.bot = a_ctl_ff.flush ? pix_type'('0) : a_pix_ff;
   end

   bb3_cell u_cell2 (.clock(clock), .shift(a_ctl_ff.vld), .col_in(new_col), .col_out(win2));
   bb3_cell u_cell1 (.clock(clock), .shift(a_ctl_ff.vld), .col_in(win2),    .col_out(win1));
   bb3_cell u_cell0 (.clock(clock), .shift(a_ctl_ff.vld), .col_in(win1),    .col_out(win0));

   always_comb begin
      sel1.up    = b_ctl_ff.up;
      sel1.down  = b_ctl_ff.down;
      sel1.left  = b_ctl_ff.left;
      sel1.right = 1'b1;
      sel2.up    = b_ctl_ff.up;
      sel2.down  = b_ctl_ff.down;
      sel2.left  = 1'b1;
      sel2.right = 1'b0;
   end

   bb3_avg u_avg1 (.clock(clock), .col_a(win0), .col_b(win1), .col_c(win2),
                   .sel(sel1), .avg(avg1));
   bb3_avg u_avg2 (.clock(clock), .col_a(win1), .col_b(win2), .col_c(win2),
                   .sel(sel2), .avg(avg2));

   always_comb begin
      push_entry.res0.out_red       = avg1.red;
      push_entry.res0.out_green     = avg1.green;
      push_entry.res0.out_blue      = avg1.blue;
      push_entry.res0.last_of_image = 1'b0;
      push_entry.res1.out_red       = avg2.red;
      push_entry.res1.out_green     = avg2.green;
      push_entry.res1.out_blue      = avg2.blue;
      push_entry.res1.last_of_image = s2_ctl_ff.last;
      push_entry.two                = s2_ctl_ff.e2;
   end

   assign push      = s2_ctl_ff.vld && s2_ctl_ff.e1;
   assign head      = fifo[rd_ptr_ff];
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = sub_ff ? head.res1 : head.res0;
   assign pop       = rsp_valid && !rsp_stall && (sub_ff || !head.two);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
         if (rsp_valid && !rsp_stall) begin
            sub_ff <= !sub_ff && head.two;
         end
      end
   end

`include "box_blur_3x3_edge_aware_unit_assert.svh"

   `BB3_ASSERT_ALWAYS(a_count_bound, count_ff <= (PW+1)'(DEPTH), "queue count overflow")
   `BB3_ASSERT_IMPLY(a_no_overfill, push && !pop, count_ff < (PW+1)'(DEPTH), "push into full queue")
   `BB3_ASSERT_IMPLY(a_sub_valid, sub_ff, rsp_valid && head.two, "second result without pair")

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   import bb3_pkg::*;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;
   localparam int   TAB_ROWS   = 24;
   localparam int   CYCLE_LIMIT = 3000000;
   localparam int   LINE_DEPTH = 1024;

   localparam req_type PIX_HI = '{mode: MODE_PIXEL, in_red: 8'hFF, in_green: 8'hFF,
                                  in_blue: 8'hFF};
   localparam req_type TICK   = '{mode: MODE_FLUSH, in_red: 8'h00, in_green: 8'h00,
                                  in_blue: 8'h00};
   localparam rsp_type BLUR_HI      = '{out_red: 8'hFF, out_green: 8'hFF, out_blue: 8'hFF,
                                        last_of_image: 1'b0};
   localparam rsp_type BLUR_HI_LAST = '{out_red: 8'hFF, out_green: 8'hFF, out_blue: 8'hFF,
                                        last_of_image: 1'b1};

   typedef struct {
      bit          is_csr;
      logic        csr_idx;
      logic [15:0] csr_val;
      req_type     pix;
      int          n_typed;
      rsp_type     typed0;
      rsp_type     typed1;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   rsp_type     blur_q[$];
   int          mismatches;
   int          cycle_count;
   int          req_idle_pct;
   int          rsp_stall_pct;
   int          requests_sent;

   logic [23:0] line_mem[0:2*LINE_DEPTH-1];
   logic [23:0] win[0:8];
   int unsigned col_pos, row_pos, flush_pos;
   logic [10:0] width_reg;
   logic [15:0] height_reg;

   stim_row_type dir_tab[TAB_ROWS];

   box_blur_3x3_edge_aware_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg < 2) ? 2 : height_reg;
   endfunction

   function automatic rsp_type window_mean(int cc, bit up, bit down, bit left, bit right,
                                           bit last);
      int unsigned s_r, s_g, s_b, cnt;
      int r0, r1, c0, c1;
      rsp_type o;
      s_r = 0; s_g = 0; s_b = 0; cnt = 0;
      r0 = up ? 0 : 1;
      r1 = down ? 2 : 1;
      c0 = left ? cc - 1 : cc;
      c1 = (right && cc < 2) ? cc + 1 : cc;
      for (int r = r0; r <= r1; r++) begin
         for (int c = c0; c <= c1; c++) begin
            s_r += win[r*3+c][23:16];
            s_g += win[r*3+c][15:8];
            s_b += win[r*3+c][7:0];
            cnt++;
         end
      end
      o.out_red       = 8'((2*s_r + cnt) / (2*cnt));
      o.out_green     = 8'((2*s_g + cnt) / (2*cnt));
      o.out_blue      = 8'((2*s_b + cnt) / (2*cnt));
      o.last_of_image = last;
      return o;
   endfunction

   task automatic shift_in(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
      for (int r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = bot;
   endtask

   task automatic blur_predict(input req_type rq, output int n, output rsp_type res[2]);
      int unsigned w, h, c, bank, other;
      logic [23:0] top, mid;
      bit up, down;
      w = eff_width();
      h = eff_height();
      bank  = (row_pos & 1) * LINE_DEPTH;
      other = ((row_pos + 1) & 1) * LINE_DEPTH;
      n = 0;
      if (rq.mode == MODE_PIXEL) begin
         if (row_pos >= h) return;
         c = (col_pos > w - 1) ? w - 1 : col_pos;
         top = line_mem[bank + c];
         mid = line_mem[other + c];
         line_mem[bank + c] = {rq.in_red, rq.in_green, rq.in_blue};
         shift_in(top, mid, {rq.in_red, rq.in_green, rq.in_blue});
         if (row_pos >= 1) begin
            up   = (row_pos - 1) > 0;
            down = (row_pos - 1) < h - 1;
            if (c >= 1) res[n++] = window_mean(1, up, down, c >= 2, 1'b1, 1'b0);
            if (c == w - 1) res[n++] = window_mean(2, up, down, 1'b1, 1'b0, 1'b0);
         end
         if (c >= w - 1) begin
            col_pos = 0;
            row_pos = row_pos + 1;
            if (row_pos >= h) begin
               row_pos   = h;
               flush_pos = 0;
            end
         end else begin
            col_pos = c + 1;
         end
      end else begin
         if (row_pos < h) return;
         c = (flush_pos > w - 1) ? w - 1 : flush_pos;
         top = line_mem[bank + c];
         mid = line_mem[other + c];
         shift_in(top, mid, 24'd0);
         if (c >= 1) res[n++] = window_mean(1, 1'b1, 1'b0, c >= 2, 1'b1, 1'b0);
         if (c == w - 1) res[n++] = window_mean(2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
         if (c >= w - 1) begin
            row_pos = 0; col_pos = 0; flush_pos = 0;
         end else begin
            flush_pos = c + 1;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic wait_idle();
      while (blur_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WIDTH) width_reg = val[10:0];
      else height_reg = val;
   endtask

   task automatic send_request(input req_type rq, input int n_typed, input rsp_type t0,
                               input rsp_type t1);
      int n;
      rsp_type res[2];
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      blur_predict(rq, n, res);
      if (n_typed >= 0) begin
         if (n_typed != n) report_mismatch("typed result count disagrees with prediction");
         if (n_typed > 0) blur_q.push_back(t0);
         if (n_typed > 1) blur_q.push_back(t1);
      end else begin
         for (int k = 0; k < n; k++) blur_q.push_back(res[k]);
      end
      requests_sent++;
   endtask

   task automatic random_pixel(output req_type rq);
      rq.mode      = MODE_PIXEL;
      rq.in_red    = 8'($urandom);
      rq.in_green  = 8'($urandom);
      rq.in_blue   = 8'($urandom);
      if ($urandom_range(9) == 0) rq.in_red = $urandom_range(1) ? 8'hFF : 8'h00;
   endtask

   task automatic stream_image(input int unsigned w, input int unsigned h, input int noise);
      req_type rq;
      for (int unsigned i = 0; i < w*h; i++) begin
         if ($urandom_range(99) < noise) begin
            random_pixel(rq);
            rq.mode = MODE_FLUSH;
            send_request(rq, -1, '0, '0);
         end
         random_pixel(rq);
         send_request(rq, -1, '0, '0);
      end
      for (int unsigned i = 0; i < w; i++) begin
         if ($urandom_range(99) < noise) begin
            random_pixel(rq);
            send_request(rq, -1, '0, '0);
         end
         random_pixel(rq);
         rq.mode = MODE_FLUSH;
         send_request(rq, -1, '0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blur_q.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            rsp_type e;
            e = blur_q.pop_front();
            if (rsp_data.out_red !== e.out_red)
               report_mismatch($sformatf("red %0h, want %0h", rsp_data.out_red, e.out_red));
            if (rsp_data.out_green !== e.out_green)
               report_mismatch($sformatf("green %0h, want %0h", rsp_data.out_green,
                                         e.out_green));
            if (rsp_data.out_blue !== e.out_blue)
               report_mismatch($sformatf("blue %0h, want %0h", rsp_data.out_blue,
                                         e.out_blue));
            if (rsp_data.last_of_image !== e.last_of_image)
               report_mismatch($sformatf("last %0b, want %0b", rsp_data.last_of_image,
                                         e.last_of_image));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int unsigned w, h;
      logic [15:0] wraw;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_WIDTH;
      csr_data = '0;
      mismatches = 0;
      cycle_count = 0;
      requests_sent = 0;
      req_idle_pct = 20;
      rsp_stall_pct = 72;
      for (int i = 0; i < 2*LINE_DEPTH; i++) line_mem[i] = '0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_pos = 0; row_pos = 0; flush_pos = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;

      dir_tab[0]  = '{1'b1, REG_WIDTH, 16'd0, '0, 0, '0, '0};
      dir_tab[1]  = '{1'b1, REG_HEIGHT, 16'd1, '0, 0, '0, '0};
      dir_tab[2]  = '{1'b0, REG_WIDTH, 16'd0, TICK, 0, '0, '0};
      dir_tab[3]  = '{1'b0, REG_WIDTH, 16'd0, PIX_HI, 0, '0, '0};
      dir_tab[4]  = '{1'b0, REG_WIDTH, 16'd0, PIX_HI, 0, '0, '0};
      dir_tab[5]  = '{1'b0, REG_WIDTH, 16'd0, PIX_HI, 0, '0, '0};
      dir_tab[6]  = '{1'b0, REG_WIDTH, 16'd0, PIX_HI, 2, BLUR_HI, BLUR_HI};
      dir_tab[7]  = '{1'b0, REG_WIDTH, 16'd0, PIX_HI, 0, '0, '0};
      dir_tab[8]  = '{1'b0, REG_WIDTH, 16'd0, TICK, 0, '0, '0};
      dir_tab[9]  = '{1'b0, REG_WIDTH, 16'd0, TICK, 2, BLUR_HI, BLUR_HI_LAST};
      dir_tab[10] = '{1'b1, REG_WIDTH, 16'd3, '0, 0, '0, '0};
      dir_tab[11] = '{1'b1, REG_HEIGHT, 16'd3, '0, 0, '0, '0};
      dir_tab[12] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'h000000}), -1, '0, '0};
      dir_tab[13] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'hFFFFFF}), -1, '0, '0};
      dir_tab[14] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'h80017F}), -1, '0, '0};
      dir_tab[15] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'h0180FE}), -1, '0, '0};
      dir_tab[16] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'hFF00FF}), -1, '0, '0};
      dir_tab[17] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'h00FF00}), -1, '0, '0};
      dir_tab[18] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'h555555}), -1, '0, '0};
      dir_tab[19] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'hAAAAAA}), -1, '0, '0};
      dir_tab[20] = '{1'b0, REG_WIDTH, 16'd0, req_type'({MODE_PIXEL, 24'h7F80FF}), -1, '0, '0};
      dir_tab[21] = '{1'b0, REG_WIDTH, 16'd0, TICK, -1, '0, '0};
      dir_tab[22] = '{1'b0, REG_WIDTH, 16'd0, TICK, -1, '0, '0};
      dir_tab[23] = '{1'b0, REG_WIDTH, 16'd0, TICK, -1, '0, '0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TAB_ROWS; i++) begin
         if (dir_tab[i].is_csr) begin
            req_valid <= 1'b0;
            wait_idle();
            write_csr(dir_tab[i].csr_idx, dir_tab[i].csr_val);
         end else begin
            send_request(dir_tab[i].pix, dir_tab[i].n_typed, dir_tab[i].typed0,
                         dir_tab[i].typed1);
         end
      end

      while (requests_sent < 700) begin
         if (requests_sent > 470) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end else if (requests_sent > 250) begin
            req_idle_pct = 72;
            rsp_stall_pct = 20;
         end
         req_valid <= 1'b0;
         wait_idle();
         case ($urandom_range(5))
            0: wraw = 16'($urandom_range(1));
            1: wraw = 16'($urandom_range(24, 10));
            default: wraw = 16'($urandom_range(9, 2));
         endcase
         h = $urandom_range(1) ? $urandom_range(6, 2) : $urandom_range(1, 0);
         write_csr(REG_WIDTH, wraw);
         write_csr(REG_HEIGHT, 16'(h));
         w = eff_width();
         stream_image(w, eff_height(), 5);
      end

      req_valid <= 1'b0;
      wait_idle();
      write_csr(REG_WIDTH, 16'd2);
      write_csr(REG_HEIGHT, 16'd20);
      stream_image(2, 20, 0);

      req_valid <= 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
